// ===== src/wlc_pkg.sv =====
// shared constants, types and functions of the write-back data cache
`default_nettype none
package wlc_pkg;
    localparam int SET_COUNT  = 256;
    localparam int WAY_COUNT  = 8;
    localparam int LINE_WORDS = 8;

    localparam int SET_W    = $clog2(SET_COUNT);
    localparam int WAY_W    = $clog2(WAY_COUNT);
    localparam int WORD_W   = $clog2(LINE_WORDS);
    localparam int OFF_W    = WORD_W + 2;
    localparam int TAG_W    = 32 - OFF_W - SET_W;
    localparam int RANK_W   = WAY_W;
    localparam int DADDR_W  = SET_W + WAY_W + WORD_W;
    localparam int DATA_DEPTH = SET_COUNT * WAY_COUNT * LINE_WORDS;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_REFILL = 2'd2;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_WB     = 2'd1;
    localparam logic [1:0] KIND_REQ    = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    typedef logic [WAY_COUNT-1:0][RANK_W-1:0] rank_row_t;
    typedef logic [WAY_COUNT-1:0][TAG_W-1:0]  tag_row_t;

    typedef struct packed {
        logic [WAY_COUNT-1:0] valid;
        logic [WAY_COUNT-1:0] dirty;
        rank_row_t            rank;
    } meta_t;

    // make way w most recent; ways ranked below its old rank age by one
    function automatic rank_row_t touch_ranks(meta_t m, logic [WAY_W-1:0] w);
        rank_row_t        r;
        logic [RANK_W:0]  old;
        r   = m.rank;
        old = m.valid[w] ? {1'b0, m.rank[w]} : (RANK_W+1)'(WAY_COUNT);
        for (int j = 0; j < WAY_COUNT; j++) begin
            if (WAY_W'(j) != w && m.valid[j] && {1'b0, m.rank[j]} < old)
                r[j] = m.rank[j] + 1'b1;
        end
        r[w] = '0;
        return r;
    endfunction

    // lowest invalid way, else oldest way, lowest on a tie
    function automatic logic [WAY_W-1:0] pick_victim(meta_t m);
        logic [WAY_W-1:0] best;
        logic             found;
        best  = '0;
        found = 1'b0;
        for (int j = 1; j < WAY_COUNT; j++) begin
            if (m.rank[j] > m.rank[best])
                best = WAY_W'(j);
        end
        for (int j = 0; j < WAY_COUNT; j++) begin
            if (!found && !m.valid[j]) begin
                best  = WAY_W'(j);
                found = 1'b1;
            end
        end
        return best;
    endfunction
endpackage
`default_nettype wire

// ===== src/writeback_lru_data_cache.sv =====
// Write-back, write-allocate 8-way LRU data cache, 256 sets of 32-byte lines.
// Slave channel: s_tuser carries the command (read, write, refill word),
// s_tdata the address, write data and refill data. Master channel: m_tuser
// carries the result kind, m_tdata hit, read data, memory address and memory
// data, m_tlast marks the last result of an input word.
// After reset a clearing pass writes the metadata memory one set per cycle,
// all 256 sets, while s_tready stays low. A hit goes from accept through the
// metadata read, then the lookup together with the data memory access, then
// the result register; the next word is accepted once the result register is
// empty, so a new word is not taken before the last result has been taken.
// A miss emits eight write-back words if the victim is dirty (each a data
// memory read, then output), then the refill request. Refill words are taken
// one per cycle while the result register is empty; the last one adds a
// metadata read and a data read or write before the done result. Accesses
// during a refill and stray refill words get one rejected result. A stalled
// receiver holds the result register and the block waits; nothing is lost.
`default_nettype none
module writeback_lru_data_cache
    import wlc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // address, write_data, refill_data
    input  wire logic [1:0]   s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // hit, read_data, mem_address, mem_data, zero pad
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);
    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_LOOK    = 8'b0000_0100,
        S_WB_RD   = 8'b0000_1000,
        S_WB_EMIT = 8'b0001_0000,
        S_REQ     = 8'b0010_0000,
        S_FILL    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    meta_t    meta_mem [SET_COUNT];
    tag_row_t tag_mem  [SET_COUNT];
    logic [31:0] data_mem [DATA_DEPTH];

    meta_t    meta_q;
    tag_row_t tag_q;
    logic [31:0] data_q;

    logic [SET_W-1:0] clr_reg;
    logic             pend_reg;
    logic [31:0]      addr_reg, wdata_reg;
    logic             is_write_reg;
    logic [WAY_W-1:0] victim_reg;
    logic [WORD_W-1:0] cnt_reg;
    logic [TAG_W-1:0] vtag_reg;
    logic             hit_reg, rd_read_reg;

    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic             out_hit_reg, out_last_reg;
    logic [31:0]      out_rd_reg, out_ma_reg, out_md_reg;

    logic [31:0] in_addr, in_wdata, in_rdata;
    assign in_addr  = s_tdata[31:0];
    assign in_wdata = s_tdata[63:32];
    assign in_rdata = s_tdata[95:64];

    logic [SET_W-1:0]  a_set, p_set;
    logic [WORD_W-1:0] p_word;
    logic [TAG_W-1:0]  p_tag;
    assign a_set  = in_addr[OFF_W +: SET_W];
    assign p_set  = addr_reg[OFF_W +: SET_W];
    assign p_word = addr_reg[2 +: WORD_W];
    assign p_tag  = addr_reg[31 -: TAG_W];

    logic accept, can_emit;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign can_emit = !out_valid_reg || m_tready;

    // lookup
    logic [WAY_COUNT-1:0] hit_vec;
    logic                 any_hit;
    logic [WAY_W-1:0]     hit_way, vic_way;
    always_comb
    begin
        hit_way = '0;
        for (int j = 0; j < WAY_COUNT; j++) begin
            hit_vec[j] = meta_q.valid[j] && (tag_q[j] == p_tag);
            if (hit_vec[j])
                hit_way = WAY_W'(j);
        end
        any_hit = |hit_vec;
        vic_way = pick_victim(meta_q);
    end

    // memory port control
    logic              meta_we, meta_re, tag_we, data_we, data_re;
    logic [SET_W-1:0]  meta_wa, meta_ra;
    meta_t             meta_wd;
    tag_row_t          tag_wd;
    logic [DADDR_W-1:0] data_wa, data_ra;
    logic [31:0]       data_wd;
    always_comb
    begin
        meta_we = 1'b0;
        meta_re = 1'b0;
        tag_we  = 1'b0;
        data_we = 1'b0;
        data_re = 1'b0;
        meta_wa = p_set;
        meta_ra = a_set;
        meta_wd = meta_q;
        tag_wd  = tag_q;
        data_wa = {p_set, victim_reg, cnt_reg};
        data_ra = {p_set, victim_reg, cnt_reg};
        data_wd = wdata_reg;
        case (state_reg)
            S_CLEAR:
            begin
                meta_we = 1'b1;
                meta_wa = clr_reg;
                meta_wd = '0;
            end
            S_IDLE:
            begin
                if (accept && s_tuser == CMD_REFILL && pend_reg) begin
                    data_we = 1'b1;
                    data_wd = in_rdata;
                    meta_re = (cnt_reg == WORD_W'(LINE_WORDS - 1));
                    meta_ra = p_set;
                end else if (accept && !pend_reg
                             && (s_tuser == CMD_READ || s_tuser == CMD_WRITE)) begin
                    meta_re = 1'b1;
                end
            end
            S_LOOK:
            begin
                meta_we = 1'b1;
                if (any_hit) begin
                    meta_wd.rank = touch_ranks(meta_q, hit_way);
                    if (is_write_reg)
                        meta_wd.dirty[hit_way] = 1'b1;
                    data_wa = {p_set, hit_way, p_word};
                    data_ra = {p_set, hit_way, p_word};
                    data_we = is_write_reg;
                    data_re = !is_write_reg;
                end else begin
                    meta_wd.valid[vic_way] = 1'b0;
                    meta_wd.dirty[vic_way] = 1'b0;
                end
            end
            S_WB_RD:
            begin
                data_re = 1'b1;
            end
            S_FILL:
            begin
                meta_we = 1'b1;
                tag_we  = 1'b1;
                meta_wd.rank = touch_ranks(meta_q, victim_reg);
                meta_wd.valid[victim_reg] = 1'b1;
                meta_wd.dirty[victim_reg] = is_write_reg;
                tag_wd[victim_reg] = p_tag;
                data_wa = {p_set, victim_reg, p_word};
                data_ra = {p_set, victim_reg, p_word};
                data_we = is_write_reg;
                data_re = !is_write_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_wa] <= meta_wd;
        if (meta_re)
            meta_q <= meta_mem[meta_ra];
        if (tag_we)
            tag_mem[p_set] <= tag_wd;
        if (meta_re)
            tag_q <= tag_mem[meta_ra];
        if (data_we)
            data_mem[data_wa] <= data_wd;
        if (data_re)
            data_q <= data_mem[data_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_reg == SET_W'(SET_COUNT - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (meta_re)
                    state_next = (s_tuser == CMD_REFILL) ? S_FILL : S_LOOK;
            S_LOOK:
                if (any_hit)
                    state_next = S_DONE;
                else if (meta_q.valid[vic_way] && meta_q.dirty[vic_way])
                    state_next = S_WB_RD;
                else
                    state_next = S_REQ;
            S_WB_RD:
                state_next = S_WB_EMIT;
            S_WB_EMIT:
                if (can_emit)
                    state_next = (cnt_reg == WORD_W'(LINE_WORDS - 1)) ? S_REQ : S_WB_RD;
            S_REQ:
                if (can_emit)
                    state_next = S_IDLE;
            S_FILL:
                state_next = S_DONE;
            S_DONE:
                if (can_emit)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                    clr_reg <= clr_reg + 1'b1;
                S_IDLE:
                begin
                    if (accept) begin
                        if (s_tuser == CMD_REFILL && pend_reg) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end else if (!pend_reg
                                     && (s_tuser == CMD_READ || s_tuser == CMD_WRITE)) begin
                            addr_reg     <= in_addr;
                            wdata_reg    <= in_wdata;
                            is_write_reg <= (s_tuser == CMD_WRITE);
                        end else begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= KIND_REJECT;
                            out_hit_reg   <= 1'b0;
                            out_rd_reg    <= '0;
                            out_ma_reg    <= '0;
                            out_md_reg    <= '0;
                            out_last_reg  <= 1'b1;
                        end
                    end
                end
                S_LOOK:
                begin
                    hit_reg     <= any_hit;
                    rd_read_reg <= !is_write_reg;
                    if (!any_hit) begin
                        victim_reg <= vic_way;
                        vtag_reg   <= tag_q[vic_way];
                        cnt_reg    <= '0;
                    end
                end
                S_WB_EMIT:
                begin
                    if (can_emit) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_WB;
                        out_hit_reg   <= 1'b0;
                        out_rd_reg    <= '0;
                        out_ma_reg    <= {vtag_reg, p_set, cnt_reg, 2'b00};
                        out_md_reg    <= data_q;
                        out_last_reg  <= 1'b0;
                        cnt_reg       <= cnt_reg + 1'b1;
                    end
                end
                S_REQ:
                begin
                    if (can_emit) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_REQ;
                        out_hit_reg   <= 1'b0;
                        out_rd_reg    <= '0;
                        out_ma_reg    <= {p_tag, p_set, {OFF_W{1'b0}}};
                        out_md_reg    <= '0;
                        out_last_reg  <= 1'b1;
                        pend_reg      <= 1'b1;
                        cnt_reg       <= '0;
                    end
                end
                S_FILL:
                begin
                    pend_reg    <= 1'b0;
                    hit_reg     <= 1'b0;
                    rd_read_reg <= !is_write_reg;
                end
                S_DONE:
                begin
                    if (can_emit) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_DONE;
                        out_hit_reg   <= hit_reg;
                        out_rd_reg    <= rd_read_reg ? data_q : wdata_reg;
                        out_ma_reg    <= '0;
                        out_md_reg    <= '0;
                        out_last_reg  <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_md_reg, out_ma_reg, out_rd_reg, out_hit_reg};
endmodule
`default_nettype wire

// ===== src/wlc_checker.sv =====
// port-level assertions for the data cache, bound to its top level
`default_nettype none
module wlc_checker
    import wlc_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic [1:0]   m_tuser,
    input wire logic         m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_WB |-> !m_tlast && !m_tdata[0])
        else $error("write-back word marked last or hit");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REQ || m_tuser == KIND_REJECT || m_tuser == KIND_DONE)
        |-> m_tlast)
        else $error("request, reject or done word without last");

    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tuser == KIND_DONE)
        else $error("hit flag outside a done word");
endmodule

bind writeback_lru_data_cache wlc_checker u_wlc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
